[design/lpom_pkg.sv]
// lpom_pkg: shared types, register map and reset constants for the low pulse occupancy meter
// no dependencies
package lpom_pkg;

    // default width of the microsecond time base
    localparam int TIME_WIDTH_DEF = 32;

    // apb register map, index = paddr[3:2]
    localparam int          ADDR_WIDTH = 4;
    localparam logic [1:0]  REG_WARMUP_ENABLE  = 2'd0;
    localparam logic [1:0]  REG_WARMUP_SECONDS = 2'd1;
    localparam logic [1:0]  REG_WINDOW_SECONDS = 2'd2;

    // register reset values
    localparam logic        RST_WARMUP_ENABLE  = 1'b1;
    localparam logic [15:0] RST_WARMUP_SECONDS = 16'd60;
    localparam logic [15:0] RST_WINDOW_SECONDS = 16'd15;

    typedef struct packed {
        logic        warmup_enable;
        logic [15:0] warmup_seconds;
        logic [15:0] window_seconds;
    } cfg_t;

    typedef struct packed {
        logic pin_active;
        logic second_strobe;
    } item_t;

endpackage

[design/low_pulse_occupancy_meter.sv]
// low pulse occupancy meter: one microsecond sample per request in, one window report out
// low time accumulated over a window of second strobes, with optional sensor warm-up
// depends on lpom_pkg, lpom_cfg, lpom_in_reg, lpom_core, lpom_out_reg
//
// usage: feed one request per microsecond carrying the sensor level (1 while its low
// pulse is active) and a flag for the microsecond that ends a second. the block
// sustains one request per clock while the report register has room: a request sits
// in the input register, the state update (one time-base increment, the pulse-length
// add and the window compare) is combinational, and a window report lands in the
// output register. after reset the block waits warmup_seconds strobes (if the package
// constant RST_WARMUP_ENABLE is set; the warmup_enable register is not used) before
// the first window; rising edges then mark pulse starts, falling edges add the pulse
// length, and each window of window_seconds strobes emits low time, window length, an
// overrun flag and a count. apb configuration is 0x0 warmup_enable, 0x4 warmup_seconds,
// 0x8 window_seconds, written by the user only while the block is idle (not enforced).
module low_pulse_occupancy_meter #(
    parameter int TIME_WIDTH = lpom_pkg::TIME_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // apb configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpom_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // sample requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_pin_active,
    input  logic                             s_second_strobe,
    // window reports
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_low_time_us,
    output logic [31:0]                      m_window_time_us,
    output logic                             m_low_exceeds_window,
    output logic [31:0]                      m_window_number
);

    lpom_pkg::cfg_t        cfg;
    lpom_pkg::item_t       s_item;
    lpom_pkg::item_t       item;
    logic                  item_valid;
    logic                  take;
    logic                  slot_free;
    logic                  res_load;
    logic [TIME_WIDTH-1:0] res_low;
    logic [TIME_WIDTH-1:0] res_end;
    logic [31:0]           res_number;

    assign s_item.pin_active    = s_pin_active;
    assign s_item.second_strobe = s_second_strobe;

    // configuration registers
    lpom_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, refills in the same cycle it drains
    lpom_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // counters, edge handling and window close, one sample per cycle while the report register has room
    lpom_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .slot_free  (slot_free),
        .take       (take),
        .res_load   (res_load),
        .res_low    (res_low),
        .res_end    (res_end),
        .res_number (res_number)
    );

    // report register, a sample advances only when a report could be stored
    lpom_out_reg #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_out_reg (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .res_load             (res_load),
        .res_low              (res_low),
        .res_end              (res_end),
        .res_number           (res_number),
        .slot_free            (slot_free),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_low_time_us        (m_low_time_us),
        .m_window_time_us     (m_window_time_us),
        .m_low_exceeds_window (m_low_exceeds_window),
        .m_window_number      (m_window_number)
    );

endmodule

[design/lpom_cfg.sv]
// lpom_cfg: apb-style configuration registers of the low pulse occupancy meter
// depends on lpom_pkg
module lpom_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lpom_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output lpom_pkg::cfg_t                   cfg
);

    lpom_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warmup_enable  <= lpom_pkg::RST_WARMUP_ENABLE;
            cfg_reg.warmup_seconds <= lpom_pkg::RST_WARMUP_SECONDS;
            cfg_reg.window_seconds <= lpom_pkg::RST_WINDOW_SECONDS;
        end else if (wr_en) begin
            unique case (reg_idx)
                lpom_pkg::REG_WARMUP_ENABLE:  cfg_reg.warmup_enable  <= pwdata[0];
                lpom_pkg::REG_WARMUP_SECONDS: cfg_reg.warmup_seconds <= pwdata[15:0];
                lpom_pkg::REG_WINDOW_SECONDS: cfg_reg.window_seconds <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lpom_pkg::REG_WARMUP_ENABLE:  prdata = {31'd0, cfg_reg.warmup_enable};
            lpom_pkg::REG_WARMUP_SECONDS: prdata = {16'd0, cfg_reg.warmup_seconds};
            lpom_pkg::REG_WINDOW_SECONDS: prdata = {16'd0, cfg_reg.window_seconds};
            default:                      prdata = '0;
        endcase
    end

endmodule

[design/lpom_in_reg.sv]
// lpom_in_reg: input register that holds one accepted sample request
// depends on lpom_pkg
module lpom_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lpom_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output lpom_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    lpom_pkg::item_t item_reg;

    // free when empty or when the held request moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[design/lpom_core.sv]
// lpom_core: measurement state and per-sample update (edges, accumulator, window close)
// depends on lpom_pkg
module lpom_core #(
    parameter int TIME_WIDTH = lpom_pkg::TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpom_pkg::cfg_t        cfg,
    input  logic                  item_valid,
    input  lpom_pkg::item_t       item,
    input  logic                  slot_free,
    output logic                  take,
    output logic                  res_load,
    output logic [TIME_WIDTH-1:0] res_low,
    output logic [TIME_WIDTH-1:0] res_end,
    output logic [31:0]           res_number
);

    logic [TIME_WIDTH-1:0] micro_count_reg, micro_count_next;
    logic [TIME_WIDTH-1:0] pulse_start_reg, pulse_start_next;
    logic [TIME_WIDTH-1:0] low_accum_reg, low_accum_next;
    logic [31:0]           second_count_reg, second_count_next;
    logic [31:0]           window_start_reg, window_start_next;
    logic [31:0]           windows_done_reg, windows_done_next;
    logic                  warmed_up_reg, warmed_up_next;
    logic                  last_level_reg;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] accum_edge;
    logic [31:0]           sec_inc;
    logic                  edge_seen;
    logic                  close_ok;
    logic                  restart;

    assign take = item_valid && slot_free;

    always_comb begin
        now        = micro_count_reg + 1'b1;
        sec_inc    = second_count_reg + 32'd1;
        edge_seen  = warmed_up_reg && (item.pin_active != last_level_reg);

        // pulse start on rise, accumulate on a release that comes after the start
        pulse_start_next = pulse_start_reg;
        accum_edge       = low_accum_reg;
        if (edge_seen && item.pin_active) begin
            pulse_start_next = now;
        end else if (edge_seen && (now > pulse_start_reg)) begin
            accum_edge = low_accum_reg + (now - pulse_start_reg);
        end

        close_ok = (now != '0) && (sec_inc > window_start_reg)
                   && ((sec_inc - window_start_reg) >= 32'(cfg.window_seconds));

        res_load          = 1'b0;
        restart           = 1'b0;
        warmed_up_next    = warmed_up_reg;
        windows_done_next = windows_done_reg;
        second_count_next = second_count_reg;
        if (item.second_strobe) begin
            second_count_next = sec_inc;
            if (!warmed_up_reg) begin
                if (sec_inc >= 32'(cfg.warmup_seconds)) begin
                    restart        = 1'b1;
                    warmed_up_next = 1'b1;
                end
            end else if (close_ok) begin
                windows_done_next = windows_done_reg + 32'd1;
                res_load          = take;
                restart           = 1'b1;
            end
        end

        micro_count_next  = restart ? '0 : now;
        low_accum_next    = restart ? '0 : accum_edge;
        window_start_next = restart ? sec_inc : window_start_reg;

        res_low    = accum_edge;
        res_end    = now;
        res_number = windows_done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            micro_count_reg  <= '0;
            pulse_start_reg  <= '0;
            low_accum_reg    <= '0;
            second_count_reg <= '0;
            window_start_reg <= '0;
            windows_done_reg <= '0;
            warmed_up_reg    <= !lpom_pkg::RST_WARMUP_ENABLE;
            last_level_reg   <= 1'b0;
        end else if (take) begin
            micro_count_reg  <= micro_count_next;
            pulse_start_reg  <= pulse_start_next;
            low_accum_reg    <= low_accum_next;
            second_count_reg <= second_count_next;
            window_start_reg <= window_start_next;
            windows_done_reg <= windows_done_next;
            warmed_up_reg    <= warmed_up_next;
            last_level_reg   <= item.pin_active;
        end
    end

    // a result only comes from a strobe sample after warm-up
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (item.second_strobe && warmed_up_reg && take))
        else $error("result without strobe after warm-up");

    // a closed window restarts the time base
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (micro_count_reg == '0 && low_accum_reg == '0))
        else $error("window not restarted after result");

    // warm-up, once over, never comes back
    assert property (@(posedge aclk) disable iff (!aresetn)
        warmed_up_reg |=> warmed_up_reg)
        else $error("warm-up flag dropped");

    // the window counter moves exactly when a result is produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        !res_load |=> $stable(windows_done_reg))
        else $error("window count moved without result");

endmodule

[design/lpom_out_reg.sv]
// lpom_out_reg: result register of the low pulse occupancy meter, with the error flag compare
// no package dependencies
module lpom_out_reg #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  res_load,
    input  logic [TIME_WIDTH-1:0] res_low,
    input  logic [TIME_WIDTH-1:0] res_end,
    input  logic [31:0]           res_number,
    output logic                  slot_free,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_low_time_us,
    output logic [31:0]           m_window_time_us,
    output logic                  m_low_exceeds_window,
    output logic [31:0]           m_window_number
);

    logic                  valid_reg, valid_next;
    logic [TIME_WIDTH-1:0] low_reg;
    logic [TIME_WIDTH-1:0] end_reg;
    logic [31:0]           number_reg;

    assign slot_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            low_reg    <= res_low;
            end_reg    <= res_end;
            number_reg <= res_number;
        end
    end

    // compare at full time width, report low 32 bits
    assign m_valid              = valid_reg;
    assign m_low_time_us        = 32'(low_reg);
    assign m_window_time_us     = 32'(end_reg);
    assign m_low_exceeds_window = low_reg > end_reg;
    assign m_window_number      = number_reg;

endmodule
